@@ rtl/core/fpssd_pkg.sv @@
// Shared types and constants of the fixed-point shift-subtract divider.
`timescale 1ns / 1ps

package fpssd_pkg;

    // Width of every payload field; the working word may be narrower.
    localparam int FIELD_BITS  = 64;
    // Depth of the item queue between the front and back parts.
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [FIELD_BITS-1:0] dividend_raw;
        logic [FIELD_BITS-1:0] divisor_raw;
    } div_in_t;

    typedef struct packed {
        logic [FIELD_BITS-1:0] quotient_raw;
        logic                  divide_by_zero;
    } div_out_t;

    // A normalised item handed from the front part to the back part.
    typedef struct packed {
        logic [FIELD_BITS-1:0] remain;
        logic [FIELD_BITS-1:0] divisor;
        logic [FIELD_BITS-1:0] bit_mask;
        logic                  div_zero;
    } norm_item_t;

    typedef enum logic {
        FRONT_IDLE,
        FRONT_NORM
    } front_state_t;

    typedef enum logic {
        BACK_IDLE,
        BACK_RUN
    } back_state_t;

endpackage

@@ rtl/core/fpssd_queue.sv @@
// Two-entry item queue between the normalising front part and the restoring back part.
`timescale 1ns / 1ps

module fpssd_queue
    import fpssd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  norm_item_t push_item,
    output logic       full,
    input  logic       pop,
    output norm_item_t pop_item,
    output logic       empty
);

    localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(QUEUE_DEPTH - 1);
    localparam logic [CNT_BITS-1:0] DEPTH_CNT = CNT_BITS'(QUEUE_DEPTH);

    norm_item_t            entries [QUEUE_DEPTH];
    logic [PTR_BITS-1:0]   wr_ptr_reg;
    logic [PTR_BITS-1:0]   wr_ptr_next;
    logic [PTR_BITS-1:0]   rd_ptr_reg;
    logic [PTR_BITS-1:0]   rd_ptr_next;
    logic [CNT_BITS-1:0]   count_reg;
    logic [CNT_BITS-1:0]   count_next;
    logic                  do_push;
    logic                  do_pop;

    assign full     = (count_reg == DEPTH_CNT);
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_item = entries[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_BITS'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_BITS'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_BITS'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries[wr_ptr_reg] <= push_item;
        end
    end

    // The fill count stays within the depth, and the pointers agree once the queue is full or empty.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_CNT)
        else $error("queue fill count beyond depth");

    a_full_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (full || empty) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with fill count");

endmodule

@@ rtl/core/fpssd_front.sv @@
// Front part: takes items, flags a zero divisor and normalises the divisor and mask.
`timescale 1ns / 1ps

module fpssd_front
    import fpssd_pkg::*;
#(
    parameter int WORD_BITS = 64
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  div_in_t    operands,
    output logic       busy,
    output logic       push,
    output norm_item_t push_item,
    input  logic       full
);

    localparam int HALF_BITS = WORD_BITS / 2;
    localparam int CNT_BITS  = $clog2(HALF_BITS + 1);
    localparam logic [CNT_BITS-1:0] HALF_CNT = CNT_BITS'(HALF_BITS);
    localparam logic [WORD_BITS-1:0] START_MASK =
        {{(WORD_BITS-1){1'b0}}, 1'b1} << HALF_BITS;

    front_state_t          state_reg;
    front_state_t          state_next;
    logic [WORD_BITS-1:0]  remain_reg;
    logic [WORD_BITS-1:0]  remain_next;
    logic [WORD_BITS-1:0]  divisor_reg;
    logic [WORD_BITS-1:0]  divisor_next;
    logic [WORD_BITS-1:0]  mask_reg;
    logic [WORD_BITS-1:0]  mask_next;
    logic                  zero_reg;
    logic                  zero_next;
    logic [CNT_BITS-1:0]   cnt_reg;
    logic [CNT_BITS-1:0]   cnt_next;
    logic                  norm_done;

    assign busy = (state_reg != FRONT_IDLE);

    // Doubling stops once the divisor has caught up with the dividend or the
    // shift budget is spent; a zero divisor skips straight to the queue.
    assign norm_done = zero_reg || (cnt_reg == HALF_CNT) || (divisor_reg >= remain_reg);

    assign push_item.remain   = FIELD_BITS'(remain_reg);
    assign push_item.divisor  = FIELD_BITS'(divisor_reg);
    assign push_item.bit_mask = FIELD_BITS'(mask_reg);
    assign push_item.div_zero = zero_reg;

    always_comb
    begin
        state_next   = state_reg;
        remain_next  = remain_reg;
        divisor_next = divisor_reg;
        mask_next    = mask_reg;
        zero_next    = zero_reg;
        cnt_next     = cnt_reg;
        push         = 1'b0;
        case (state_reg)
            FRONT_IDLE:
            begin
                if (start)
                begin
                    remain_next  = operands.dividend_raw[WORD_BITS-1:0];
                    divisor_next = operands.divisor_raw[WORD_BITS-1:0];
                    mask_next    = START_MASK;
                    zero_next    = (operands.divisor_raw[WORD_BITS-1:0] == '0);
                    cnt_next     = '0;
                    state_next   = FRONT_NORM;
                end
            end
            FRONT_NORM:
            begin
                if (norm_done)
                begin
                    if (!full)
                    begin
                        push       = 1'b1;
                        state_next = FRONT_IDLE;
                    end
                end
                else
                begin
                    divisor_next = divisor_reg << 1;
                    mask_next    = mask_reg << 1;
                    cnt_next     = cnt_reg + CNT_BITS'(1);
                end
            end
            default:
            begin
                state_next = FRONT_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FRONT_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        remain_reg  <= remain_next;
        divisor_reg <= divisor_next;
        mask_reg    <= mask_next;
        zero_reg    <= zero_next;
    end

endmodule

@@ rtl/core/fpssd_back.sv @@
// Back part: restoring subtract-and-shift steps on one normalised item at a time.
`timescale 1ns / 1ps

module fpssd_back
    import fpssd_pkg::*;
#(
    parameter int WORD_BITS      = 64,
    parameter int QUOTIENT_STEPS = 32
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       empty,
    input  norm_item_t pop_item,
    output logic       pop,
    output logic       done,
    output div_out_t   result
);

    localparam int STEP_BITS = $clog2(QUOTIENT_STEPS + 1);
    localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(QUOTIENT_STEPS);

    back_state_t           state_reg;
    back_state_t           state_next;
    logic [WORD_BITS-1:0]  remain_reg;
    logic [WORD_BITS-1:0]  remain_next;
    logic [WORD_BITS-1:0]  divisor_reg;
    logic [WORD_BITS-1:0]  divisor_next;
    logic [WORD_BITS-1:0]  mask_reg;
    logic [WORD_BITS-1:0]  mask_next;
    logic [WORD_BITS-1:0]  quot_reg;
    logic [WORD_BITS-1:0]  quot_next;
    logic                  zero_reg;
    logic                  zero_next;
    logic [STEP_BITS-1:0]  step_reg;
    logic [STEP_BITS-1:0]  step_next;
    logic                  done_reg;
    logic                  done_next;
    div_out_t              result_reg;
    div_out_t              result_next;
    logic                  finished;

    assign done   = done_reg;
    assign result = result_reg;

    // A mask shifted out of the word ends the item with whatever is gathered.
    assign finished = zero_reg || (mask_reg == '0) || (step_reg == LAST_STEP);

    always_comb
    begin
        state_next   = state_reg;
        remain_next  = remain_reg;
        divisor_next = divisor_reg;
        mask_next    = mask_reg;
        quot_next    = quot_reg;
        zero_next    = zero_reg;
        step_next    = step_reg;
        done_next    = 1'b0;
        result_next  = result_reg;
        pop          = 1'b0;
        case (state_reg)
            BACK_IDLE:
            begin
                if (!empty)
                begin
                    pop          = 1'b1;
                    remain_next  = pop_item.remain[WORD_BITS-1:0];
                    divisor_next = pop_item.divisor[WORD_BITS-1:0];
                    mask_next    = pop_item.bit_mask[WORD_BITS-1:0];
                    zero_next    = pop_item.div_zero;
                    quot_next    = '0;
                    step_next    = '0;
                    state_next   = BACK_RUN;
                end
            end
            BACK_RUN:
            begin
                if (finished)
                begin
                    done_next                  = 1'b1;
                    result_next.quotient_raw   = FIELD_BITS'(quot_reg);
                    result_next.divide_by_zero = zero_reg;
                    state_next                 = BACK_IDLE;
                end
                else
                begin
                    if (remain_reg >= divisor_reg)
                    begin
                        remain_next = remain_reg - divisor_reg;
                        quot_next   = quot_reg + mask_reg;
                    end
                    divisor_next = divisor_reg >> 1;
                    mask_next    = mask_reg >> 1;
                    step_next    = step_reg + STEP_BITS'(1);
                end
            end
            default:
            begin
                state_next = BACK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BACK_IDLE;
            step_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        remain_reg  <= remain_next;
        divisor_reg <= divisor_next;
        mask_reg    <= mask_next;
        quot_reg    <= quot_next;
        zero_reg    <= zero_next;
        result_reg  <= result_next;
    end

    a_done_after_run: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(state_reg) == BACK_RUN) && (state_reg == BACK_IDLE))
        else $error("result strobe without a finished item");

    a_zero_quotient: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.divide_by_zero) |-> (result.quotient_raw == '0))
        else $error("zero divisor gave a non-zero quotient");

    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BACK_RUN) |-> (step_reg <= LAST_STEP))
        else $error("restoring step count overran");

endmodule

@@ rtl/core/fixed_point_shift_subtract_divider.sv @@
// Top level of the unsigned fixed-point restoring divider.
`timescale 1ns / 1ps

// Divides an unsigned fixed-point dividend by a divisor of the same format
// (Q32.32 at the default WORD_BITS of 64) and gives one quotient per item,
// with divide_by_zero set and the quotient zero when the divisor is zero.
// An item is taken when start is high and busy is low. The front part then
// doubles the divisor and mask until the divisor reaches the dividend or its
// shift budget is spent, and hands the item to a two-entry queue, waiting
// while the queue is full; the back part pops it and runs one restoring step
// per cycle while the front part normalises the next item in parallel. The
// result appears on result for exactly one cycle with done high; the
// receiver cannot stall it, so it must take every result in that cycle.

module fixed_point_shift_subtract_divider
    import fpssd_pkg::*;
#(
    parameter int WORD_BITS      = 64,
    parameter int QUOTIENT_STEPS = 32
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  div_in_t  operands,
    output logic     done,
    output div_out_t result
);

    logic       q_push;
    logic       q_pop;
    logic       q_full;
    logic       q_empty;
    norm_item_t q_push_item;
    norm_item_t q_pop_item;

    fpssd_front #(
        .WORD_BITS (WORD_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .operands  (operands),
        .busy      (busy),
        .push      (q_push),
        .push_item (q_push_item),
        .full      (q_full)
    );

    fpssd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_push_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_item  (q_pop_item),
        .empty     (q_empty)
    );

    fpssd_back #(
        .WORD_BITS      (WORD_BITS),
        .QUOTIENT_STEPS (QUOTIENT_STEPS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .empty    (q_empty),
        .pop_item (q_pop_item),
        .pop      (q_pop),
        .done     (done),
        .result   (result)
    );

endmodule

@@ test/tb_top.sv @@
// Self-checking testbench for the unsigned Q32.32 restoring divider.
`timescale 1ns / 1ps

module tb_top;
    import fpssd_pkg::*;

    localparam logic [63:0] ONE_Q   = 64'h0000_0001_0000_0000;
    localparam logic [63:0] ALL_ONE = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] TOP_BIT = 64'h8000_0000_0000_0000;
    localparam int          TAIL_CYCLES = 120;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     start = 1'b0;
    logic     busy;
    div_in_t  operands = '0;
    logic     done;
    div_out_t result;

    div_out_t pending_quotients[$];
    int       mismatch_count = 0;
    int       quotients_checked = 0;
    int       zero_divisors_seen = 0;
    int       items_accepted = 0;
    bit       gaps_enabled = 1'b1;

    fixed_point_shift_subtract_divider u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .operands (operands),
        .done     (done),
        .result   (result)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Normalise the divisor against the dividend, then form up to 32 quotient
    // bits by restoring subtraction. All shifts wrap at 64 bits.
    function automatic div_out_t divide_q32(input div_in_t x);
        logic [63:0] remainder;
        logic [63:0] shifted_divisor;
        logic [63:0] quotient_bit;
        logic [63:0] quotient;
        int          k;
        div_out_t    y;
        remainder       = x.dividend_raw;
        shifted_divisor = x.divisor_raw;
        quotient_bit    = ONE_Q;
        quotient        = '0;
        y               = '0;
        if (shifted_divisor == '0)
        begin
            y.divide_by_zero = 1'b1;
            return y;
        end
        k = 0;
        while (k < 32 && shifted_divisor < remainder)
        begin
            shifted_divisor = shifted_divisor << 1;
            quotient_bit    = quotient_bit << 1;
            k++;
        end
        k = 0;
        while (k < 32 && quotient_bit != '0)
        begin
            if (remainder >= shifted_divisor)
            begin
                remainder = remainder - shifted_divisor;
                quotient  = quotient + quotient_bit;
            end
            shifted_divisor = shifted_divisor >> 1;
            quotient_bit    = quotient_bit >> 1;
            k++;
        end
        y.quotient_raw = quotient;
        return y;
    endfunction

    // Records each accepted item and checks each quotient as it appears.
    always @(posedge clk)
    begin
        div_out_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (pending_quotients.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: expected no result, got quotient=%h dbz=%b", $time,
                             result.quotient_raw, result.divide_by_zero);
                end
                else
                begin
                    want = pending_quotients.pop_front();
                    quotients_checked++;
                    if (want.divide_by_zero)
                        zero_divisors_seen++;
                    if (result.quotient_raw !== want.quotient_raw ||
                        result.divide_by_zero !== want.divide_by_zero)
                    begin
                        mismatch_count++;
                        $display("%0t: mismatch expected quotient=%h dbz=%b,",
                                 $time, want.quotient_raw, want.divide_by_zero,
                                 " got quotient=%h dbz=%b",
                                 result.quotient_raw, result.divide_by_zero);
                    end
                end
            end
            if (start && !busy)
            begin
                pending_quotients.push_back(divide_q32(operands));
                items_accepted++;
            end
        end
    end

    // Presents one item, after a random gap when gaps are enabled, and returns
    // at the edge that accepts it.
    task automatic send_item(input logic [63:0] dividend, input logic [63:0] divisor);
        int      gap;
        div_in_t x;
        gap = 0;
        x.dividend_raw = dividend;
        x.divisor_raw  = divisor;
        if (gaps_enabled)
            while ($urandom_range(0, 99) < 14)
                gap++;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start    <= 1'b1;
        operands <= x;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (pending_quotients.size() != 0)
            @(posedge clk);
    endtask

    // Wide spread of magnitudes, with zeros, all-ones, single-bit and single-clear-bit words.
    function automatic logic [63:0] random_word();
        logic [63:0] w;
        int          top;
        w = {$urandom, $urandom};
        case ($urandom_range(0, 15))
            0: w = '0;
            1: w = ALL_ONE;
            2: w = 64'd1 << $urandom_range(0, 63);
            3: w = ~(64'd1 << $urandom_range(0, 63));
            default:
            begin
                top = $urandom_range(1, 64);
                if (top < 64)
                    w = w & ((64'd1 << top) - 64'd1);
            end
        endcase
        return w;
    endfunction

    task automatic test_special_cases();
        send_item('0, '0);
        send_item(ALL_ONE, '0);
        send_item(ONE_Q, ONE_Q);
        send_item(3 * ONE_Q, 2 * ONE_Q);
        send_item(ONE_Q, 3 * ONE_Q);
        send_item(64'd5, 64'd3);
        send_item('0, ONE_Q);
        send_item(64'd1, ALL_ONE);
        send_item(ALL_ONE, ALL_ONE);
        send_item(64'd1, 64'd1);
        // The mask is shifted out of the word, so the quotient is zero.
        send_item(ONE_Q, 64'd1);
        send_item(ALL_ONE, 64'd1);
        send_item(ALL_ONE, ONE_Q);
        send_item(ONE_Q, 64'd2);
        send_item(TOP_BIT, ONE_Q);
        // Divisor bits are pushed past the top of the word while normalising.
        send_item(ALL_ONE, TOP_BIT);
        send_item(ALL_ONE, 64'hC000_0000_0000_0001);
        send_item(ALL_ONE, 64'h9000_0000_0000_0000);
        send_item(TOP_BIT, TOP_BIT - 64'd1);
        send_item(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
        send_item(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
    endtask

    task automatic test_random_operands(input int count);
        repeat (count)
            send_item(random_word(), random_word());
    endtask

    task automatic test_back_to_back(input int count);
        gaps_enabled = 1'b0;
        repeat (count)
            send_item(random_word(), random_word());
        gaps_enabled = 1'b1;
    endtask

    task automatic test_drained_batches(input int batches);
        repeat (batches)
        begin
            repeat ($urandom_range(5, 25))
                send_item(random_word(), random_word());
            wait_drained();
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_special_cases();
        test_random_operands(700);
        test_back_to_back(350);
        test_drained_batches(10);
        test_random_operands(30);
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_quotients.size() != 0)
        begin
            mismatch_count++;
            $display("%0t: %0d expected results never arrived", $time,
                     pending_quotients.size());
        end
        $display("Divided %0d items and checked %0d quotients, %0d of them by a zero divisor,",
                 items_accepted, quotients_checked, zero_divisors_seen);
        $display("covering corner operands, random gaps, back-to-back items and drained batches.");
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

@@ fixed_point_shift_subtract_divider.f @@
rtl/core/fpssd_pkg.sv
rtl/core/fpssd_queue.sv
rtl/core/fpssd_front.sv
rtl/core/fpssd_back.sv
rtl/core/fixed_point_shift_subtract_divider.sv
test/tb_top.sv
